// ===== rtl/core/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the character stream tokeniser
// Holds the request payload types, token kind codes, keyword tables and the
// sizing constants used by the front end, the token queue and the back end.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Width of the character position counter. The reported start position is
  // this counter cut or zero-extended to sixteen bits.
  localparam int POSITION_BITS = 16;

  localparam int KW_COUNT    = 14;
  localparam int KW_MAX_LEN  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Token kind codes.
  localparam logic [2:0] KIND_KEYWORD    = 3'd0;
  localparam logic [2:0] KIND_IDENTIFIER = 3'd1;
  localparam logic [2:0] KIND_INTEGER    = 3'd2;
  localparam logic [2:0] KIND_FLOAT      = 3'd3;
  localparam logic [2:0] KIND_OPERATOR   = 3'd4;
  localparam logic [2:0] KIND_DELIMITER  = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN    = 3'd6;

  localparam logic [KW_COUNT-1:0] KW_ALL = {KW_COUNT{1'b1}};

  // Keyword spellings, one character per slot, padded with zero bytes.
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "w", "i", "t", "c", "h", 8'h00, 8'h00},
    '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "e", "f", "a", "u", "l", "t", 8'h00},
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3,
    4'd6, 4'd4, 4'd7, 4'd5, 4'd8, 4'd6, 4'd4
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } cst_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
  } cst_out_t;

endpackage

// ===== rtl/core/char_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// char_stream_tokenizer: keyword, identifier and number lexer
// Top level joining the classifying front end, the token queue and the
// registered output stage.
// ----------------------------------------------------------------------------
// The block takes one character request per clock cycle and turns the stream
// into tokens, each given as kind, start position and length, with the last
// token caused by a character marked. A word or number is reported when the
// character that ends it arrives, or when the character marked as end of text
// has been taken in; one character can therefore produce two tokens. The
// front end keeps the pending token state and accepts a character whenever
// the four-entry token queue has room for two more tokens, so characters flow
// at one per cycle for as long as tokens are drained on average as fast as
// they are produced; a stream that produces two tokens per character is paced
// by the single-token output stage. The tokens of a character are written into
// the queue when that character is accepted and reach the output through the
// registered output stage once the tokens ahead of them have been taken.
// There is no configuration and no start-up pass.
// ----------------------------------------------------------------------------
module char_stream_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_ready,
  input  cst_pkg::cst_in_t   char_data,
  output logic               token_valid,
  input  logic               token_ready,
  output cst_pkg::cst_out_t  token_data
);
  import cst_pkg::*;

  logic       space_ok;
  logic [1:0] push_count;
  cst_out_t   push_tok [2];
  logic       head_valid;
  cst_out_t   head_tok;
  logic       pop;

  // A character is taken only when the queue can hold both tokens it may make.
  assign char_ready = space_ok;

  cst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_data  (char_data),
    .space_ok   (space_ok),
    .push_count (push_count),
    .push_tok   (push_tok)
  );

  // The queue decouples character intake from token delivery.
  cst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_tok   (push_tok),
    .pop        (pop),
    .space_ok   (space_ok),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  // The back end holds the token offered to the consumer.
  cst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_tok    (head_tok),
    .pop         (pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data)
  );

endmodule

// ===== rtl/core/cst_front.sv =====
// ----------------------------------------------------------------------------
// cst_front: character classifier and token builder
// Accepts one character per cycle while space_ok is high, tracks the pending
// word or number and hands zero, one or two finished tokens to the queue.
// ----------------------------------------------------------------------------
module cst_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  input  cst_pkg::cst_in_t   char_data,
  input  logic               space_ok,
  output logic [1:0]         push_count,
  output cst_pkg::cst_out_t  push_tok [2]
);
  import cst_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER
  } mode_t;

  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] char_position;
  logic [POSITION_BITS-1:0] pending_start, pending_start_next;
  logic [15:0]              pending_length, pending_length_next;
  logic [KW_COUNT-1:0]      keyword_alive, keyword_alive_next;
  logic                     seen_dot, seen_dot_next;

  logic       accept;
  logic [7:0] c;
  logic       is_letter, is_digit, is_space, is_op, is_delim;
  logic       pending, handled, flush_now, single_v, eot_v;
  cst_out_t   flush_tok, single_tok, eot_tok, second_tok;
  logic [1:0] tok_count;

  function automatic logic [KW_COUNT-1:0] filter_alive(
    input logic [KW_COUNT-1:0] alive,
    input logic [15:0]         idx,
    input logic [7:0]          ch
  );
    logic [KW_COUNT-1:0] res;
    res = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (alive[k] && (idx < 16'(KW_LEN[k])) &&
          (KW_TEXT[k][idx[$clog2(KW_MAX_LEN)-1:0]] == ch)) begin
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] flush_kind(
    input mode_t               m,
    input logic [KW_COUNT-1:0] alive,
    input logic [15:0]         len,
    input logic                dot
  );
    logic [KW_COUNT-1:0] len_match;
    logic [2:0]          kind;
    for (int k = 0; k < KW_COUNT; k++) begin
      len_match[k] = (len == 16'(KW_LEN[k]));
    end
    case (m)
      MODE_WORD: begin
        kind = (|(alive & len_match)) ? KIND_KEYWORD : KIND_IDENTIFIER;
      end
      default: begin
        kind = dot ? KIND_FLOAT : KIND_INTEGER;
      end
    endcase
    return kind;
  endfunction

  assign accept = char_valid && space_ok;

  always_comb begin
    c         = char_data.char_code;
    is_letter = c inside {["a":"z"], ["A":"Z"]};
    is_digit  = c inside {["0":"9"]};
    is_space  = c inside {" ", 8'h09, 8'h0A, 8'h0D};
    is_op     = c inside {"+", "-", "*", "/", "%"};
    is_delim  = c inside {"(", ")", ":", "[", "]"};

    pending = (mode == MODE_WORD) || (mode == MODE_NUMBER);
    handled = ((mode == MODE_WORD) && (is_letter || is_digit)) ||
              ((mode == MODE_NUMBER) && (is_digit || (c == ".")));
    flush_now = pending && !handled;

    flush_tok.token_kind   = flush_kind(mode, keyword_alive, pending_length, seen_dot);
    flush_tok.token_start  = 16'(pending_start);
    flush_tok.token_length = pending_length;
    flush_tok.last_of_run  = 1'b0;

    mode_next           = MODE_IDLE;
    pending_start_next  = '0;
    pending_length_next = '0;
    keyword_alive_next  = '0;
    seen_dot_next       = 1'b0;
    single_v            = 1'b0;
    single_tok.token_kind   = KIND_UNKNOWN;
    single_tok.token_start  = 16'(char_position);
    single_tok.token_length = 16'd1;
    single_tok.last_of_run  = 1'b0;

    if (handled) begin
      mode_next           = mode;
      pending_start_next  = pending_start;
      pending_length_next = (pending_length == 16'hFFFF) ? pending_length
                                                         : pending_length + 16'd1;
      keyword_alive_next  = filter_alive(keyword_alive, pending_length, c);
      seen_dot_next       = seen_dot || (c == ".");
    end else if (is_space) begin
      mode_next = MODE_IDLE;
    end else if (is_letter) begin
      mode_next           = MODE_WORD;
      pending_start_next  = char_position;
      pending_length_next = 16'd1;
      keyword_alive_next  = filter_alive(KW_ALL, 16'd0, c);
    end else if (is_digit) begin
      mode_next           = MODE_NUMBER;
      pending_start_next  = char_position;
      pending_length_next = 16'd1;
    end else begin
      single_v = 1'b1;
      if (is_op) begin
        single_tok.token_kind = KIND_OPERATOR;
      end else if (is_delim) begin
        single_tok.token_kind = KIND_DELIMITER;
      end
    end

    // The end mark flushes whatever is pending once this character is in.
    eot_v = char_data.end_of_text && (mode_next != MODE_IDLE);
    eot_tok.token_kind   = flush_kind(mode_next, keyword_alive_next,
                                      pending_length_next, seen_dot_next);
    eot_tok.token_start  = 16'(pending_start_next);
    eot_tok.token_length = pending_length_next;
    eot_tok.last_of_run  = 1'b0;

    second_tok = single_v ? single_tok : eot_tok;

    push_tok[0] = second_tok;
    push_tok[1] = second_tok;
    tok_count   = 2'd0;
    if (flush_now) begin
      push_tok[0] = flush_tok;
      tok_count   = (single_v || eot_v) ? 2'd2 : 2'd1;
    end else if (single_v || eot_v) begin
      tok_count = 2'd1;
    end
    push_tok[0].last_of_run = (tok_count == 2'd1);
    push_tok[1].last_of_run = 1'b1;

    push_count = accept ? tok_count : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      char_position  <= '0;
      pending_start  <= '0;
      pending_length <= '0;
      keyword_alive  <= '0;
      seen_dot       <= 1'b0;
    end else if (accept) begin
      if (char_data.end_of_text) begin
        mode           <= MODE_IDLE;
        char_position  <= '0;
        pending_start  <= '0;
        pending_length <= '0;
        keyword_alive  <= '0;
        seen_dot       <= 1'b0;
      end else begin
        mode           <= mode_next;
        char_position  <= char_position + 1'b1;
        pending_start  <= pending_start_next;
        pending_length <= pending_length_next;
        keyword_alive  <= keyword_alive_next;
        seen_dot       <= seen_dot_next;
      end
    end
  end

endmodule

// ===== rtl/core/cst_queue.sv =====
// ----------------------------------------------------------------------------
// cst_queue: short token queue between front end and back end
// Takes up to two tokens per cycle; gives one per cycle, in order, on pop.
// ----------------------------------------------------------------------------
module cst_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_count,
  input  cst_pkg::cst_out_t  push_tok [2],
  input  logic               pop,
  output logic               space_ok,
  output logic               head_valid,
  output cst_pkg::cst_out_t  head_tok
);
  import cst_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cst_out_t              entry [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]         count;
  logic                  do_pop;

  // Room for the worst case of two tokens from one character.
  assign space_ok   = (count <= CW'(QUEUE_DEPTH - 2));
  assign head_valid = (count != '0);
  assign head_tok   = entry[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entry[wr_ptr] <= push_tok[0];
    end
    if (push_count == 2'd2) begin
      entry[wr_ptr + 1'b1] <= push_tok[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_AW'(push_count);
      rd_ptr <= rd_ptr + QUEUE_AW'(do_pop);
      count  <= count + CW'(push_count) - CW'(do_pop);
    end
  end

endmodule

// ===== rtl/core/cst_back.sv =====
// ----------------------------------------------------------------------------
// cst_back: token output stage
// Registers the head of the token queue and presents it on the output
// channel, refilling in the same cycle the current token is taken.
// ----------------------------------------------------------------------------
module cst_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  cst_pkg::cst_out_t  head_tok,
  output logic               pop,
  output logic               token_valid,
  input  logic               token_ready,
  output cst_pkg::cst_out_t  token_data
);
  import cst_pkg::*;

  assign pop = head_valid && (!token_valid || token_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (!token_valid || token_ready) begin
      token_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      token_data <= head_tok;
    end
  end

endmodule

// ===== test/char_stream_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// char_stream_tokenizer_tb: self-checking bench for the character tokeniser
// Streams character requests into the block, predicts every token from a
// behavioural lexer of its own and checks each token as it leaves the block.
// ----------------------------------------------------------------------------
module char_stream_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  // Sized for some 550 requests at up to two tokens each, with the receiver
  // stalling at most half of the time; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT      = 50000;
  localparam int SETTLE_CYCLES    = 20;
  localparam int RANDOM_PER_PHASE = 160;
  // Longer than every keyword, so that all keyword match bits die while the
  // word is still open.
  localparam int LONG_WORD_CHARS  = 40;

  typedef enum logic [1:0] {LEX_IDLE, LEX_WORD, LEX_NUMBER} lex_mode_t;

  logic     clk         = 1'b0;
  logic     rst         = 1'b1;
  logic     char_valid  = 1'b0;
  logic     char_ready;
  cst_in_t  char_data   = '0;
  logic     token_valid;
  logic     token_ready = 1'b0;
  cst_out_t token_data;

  char_stream_tokenizer uut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_data   (char_data),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_data  (token_data)
  );

  // Keyword spellings, in the order of the keyword match bits.
  string keyword_spelling [KW_COUNT] = '{
    "int", "float", "string", "if", "else", "while", "for",
    "switch", "case", "default", "break", "continue", "return", "void"
  };

  // Character requests still to be sent, and tokens still to arrive.
  cst_in_t  char_queue[$];
  cst_out_t expected_tokens[$];
  cst_out_t step_tokens[$];

  // Traffic shaping, changed only on the falling edge.
  int unsigned sender_idle_pct    = 16;
  int unsigned receiver_stall_pct = 50;
  bit          hold_sender        = 1'b0;

  int error_count = 0;
  int cycle_count = 0;

  // Lexer state of the prediction.
  lex_mode_t           lex_mode   = LEX_IDLE;
  logic [15:0]         lex_pos    = '0;
  logic [15:0]         word_start = '0;
  logic [15:0]         word_len   = '0;
  logic [KW_COUNT-1:0] kw_live    = '0;
  logic                has_dot    = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Keeps the keywords whose character at position idx equals c.
  function automatic logic [KW_COUNT-1:0] narrow_keywords(logic [KW_COUNT-1:0] live,
                                                          int unsigned idx,
                                                          logic [7:0] c);
    logic [KW_COUNT-1:0] keep;
    int k;
    keep = '0;
    for (k = 0; k < KW_COUNT; k++) begin
      if (live[k] && idx < keyword_spelling[k].len() && keyword_spelling[k][idx] == c) begin
        keep[k] = 1'b1;
      end
    end
    return keep;
  endfunction

  function automatic void add_single(logic [2:0] kind, logic [15:0] pos);
    cst_out_t t;
    t.token_kind   = kind;
    t.token_start  = pos;
    t.token_length = 16'd1;
    t.last_of_run  = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  // Emits the open word or number and returns the lexer to idle. A word is a
  // keyword only if some keyword survived every character and has its length.
  function automatic void close_pending();
    cst_out_t t;
    int k;
    t.token_kind = has_dot ? KIND_FLOAT : KIND_INTEGER;
    if (lex_mode == LEX_WORD) begin
      t.token_kind = KIND_IDENTIFIER;
      for (k = 0; k < KW_COUNT; k++) begin
        if (kw_live[k] && word_len == keyword_spelling[k].len()) begin
          t.token_kind = KIND_KEYWORD;
        end
      end
    end
    t.token_start  = word_start;
    t.token_length = word_len;
    t.last_of_run  = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
    lex_mode   = LEX_IDLE;
    word_start = '0;
    word_len   = '0;
    kw_live    = '0;
    has_dot    = 1'b0;
  endfunction

  // Works out the tokens caused by one accepted character request.
  function automatic void predict_tokens(cst_in_t item);
    logic [7:0] c;
    bit         open_token;
    bit         grows;
    int         i;
    c          = item.char_code;
    open_token = (lex_mode == LEX_WORD) || (lex_mode == LEX_NUMBER);
    grows      = 1'b0;
    step_tokens.delete();

    if (lex_mode == LEX_WORD && (is_letter(c) || is_digit(c))) begin
      grows = 1'b1;
    end else if (lex_mode == LEX_NUMBER && (is_digit(c) || c == ".")) begin
      grows = 1'b1;
      if (c == ".") begin
        has_dot = 1'b1;
      end
    end else if (open_token) begin
      close_pending();
    end

    if (grows) begin
      kw_live = narrow_keywords(kw_live, word_len, c);
      if (word_len != 16'hFFFF) begin
        word_len = word_len + 16'd1;
      end
    end else if (is_letter(c)) begin
      lex_mode   = LEX_WORD;
      word_start = lex_pos;
      word_len   = 16'd1;
      has_dot    = 1'b0;
      kw_live    = narrow_keywords(KW_ALL, 0, c);
    end else if (is_digit(c)) begin
      lex_mode   = LEX_NUMBER;
      word_start = lex_pos;
      word_len   = 16'd1;
      has_dot    = 1'b0;
      kw_live    = '0;
    end else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%") begin
      add_single(KIND_OPERATOR, lex_pos);
    end else if (c == "(" || c == ")" || c == ":" || c == "[" || c == "]") begin
      add_single(KIND_DELIMITER, lex_pos);
    end else if (!(c == " " || c == "\t" || c == "\n" || c == "\r")) begin
      add_single(KIND_UNKNOWN, lex_pos);
    end

    // The end mark flushes whatever is still open and restarts the count.
    if (item.end_of_text) begin
      if (lex_mode != LEX_IDLE) begin
        close_pending();
      end
      lex_pos = '0;
    end else begin
      lex_pos = lex_pos + 16'd1;
    end

    if (step_tokens.size() > 0) begin
      step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
    end
    for (i = 0; i < step_tokens.size(); i++) begin
      expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic check_token(cst_out_t got);
    cst_out_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected token: kind %0d start %0d length %0d",
                                got.token_kind, got.token_start, got.token_length));
    end else begin
      want = expected_tokens.pop_front();
      compare_field("token_kind",   16'(got.token_kind),  16'(want.token_kind));
      compare_field("token_start",  got.token_start,      want.token_start);
      compare_field("token_length", got.token_length,     want.token_length);
      compare_field("last_of_run",  16'(got.last_of_run), 16'(want.last_of_run));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next queued character whenever the previous request
  // has gone and the sender is not idling. A request once offered is held
  // unchanged until the block takes it, and the prediction is made on the
  // edge at which it is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      if (char_valid && char_ready) begin
        predict_tokens(char_data);
      end
      if (!char_valid || char_ready) begin
        if (char_queue.size() > 0 && !hold_sender &&
            $urandom_range(99) >= sender_idle_pct) begin
          char_data  <= char_queue.pop_front();
          char_valid <= 1'b1;
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted token and stalls the output at random.
  always @(posedge clk) begin
    if (rst) begin
      token_ready <= 1'b0;
    end else begin
      if (token_valid && token_ready) begin
        check_token(token_data);
      end
      token_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // A hung handshake must not hang the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic push_char(logic [7:0] c, bit mark_end);
    cst_in_t item;
    item.char_code   = c;
    item.end_of_text = mark_end;
    char_queue.insert(char_queue.size(), item);
  endtask

  task automatic push_text(string s, bit mark_end);
    int i;
    for (i = 0; i < s.len(); i++) begin
      push_char(s[i], mark_end && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // Mostly well-formed source text: keywords (some cut short, extended or
  // capitalised so that they only nearly match), identifiers, numbers with
  // and without dots, operators, delimiters and whitespace, with raw bytes
  // as noise and an end mark now and then.
  task automatic add_random_text(int count);
    logic [7:0] piece[$];
    int         added;
    int         pick;
    int         n;
    int         i;
    string      kw;
    added = 0;
    while (added < count) begin
      piece.delete();
      pick = $urandom_range(99);
      if (pick < 22) begin
        kw = keyword_spelling[$urandom_range(KW_COUNT - 1)];
        for (i = 0; i < kw.len(); i++) begin
          piece.insert(piece.size(), kw[i]);
        end
        case ($urandom_range(7))
          0: begin
            n = $urandom_range(kw.len() - 1, 1);
            while (piece.size() > n) begin
              void'(piece.pop_back());
            end
          end
          1: piece.insert(piece.size(), pick_char("abcxyz019"));
          2: piece[0] = piece[0] - 8'd32;
          default: ;
        endcase
      end else if (pick < 40) begin
        piece.insert(piece.size(),
                     pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        n = $urandom_range(6);
        for (i = 0; i < n; i++) begin
          piece.insert(piece.size(), pick_char("abefinorstuvwzAMQZ0123456789"));
        end
      end else if (pick < 55) begin
        piece.insert(piece.size(), pick_char("0123456789"));
        n = $urandom_range(5);
        for (i = 0; i < n; i++) begin
          piece.insert(piece.size(), pick_char("0123456789."));
        end
      end else if (pick < 65) begin
        piece.insert(piece.size(), pick_char("+-*/%"));
      end else if (pick < 73) begin
        piece.insert(piece.size(), pick_char("()[]:"));
      end else if (pick < 88) begin
        piece.insert(piece.size(), pick_char(" \t\n\r "));
      end else begin
        piece.insert(piece.size(), 8'($urandom_range(255)));
      end
      for (i = 0; i < piece.size(); i++) begin
        push_char(piece[i], $urandom_range(24) == 0);
      end
      added += piece.size();
    end
  endtask

  // Waits on the falling edge until every request has gone and every token
  // has been checked.
  task automatic wait_drained();
    while (char_queue.size() > 0 || char_valid || expected_tokens.size() > 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int i;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: the sender idles a little, the receiver often.
    sender_idle_pct    = 16;
    receiver_stall_pct = 50;

    // Directed text. A keyword and an identifier closed by a delimiter, so
    // that one character gives two tokens.
    push_text("if (x9)", 1'b0);
    // A float closed by an operator, then every operator.
    push_text("3.5/-*%+", 1'b0);
    // An integer and the remaining delimiters.
    push_text("7:[]", 1'b0);
    // Bytes outside the printable range give unknown tokens.
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h80, 1'b0);
    // An end mark on whitespace that closes a word.
    push_text("ab", 1'b0);
    push_char("\n", 1'b1);
    push_char("\r", 1'b0);
    // An end mark on a letter flushes the keyword still open.
    push_text("for", 1'b1);

    add_random_text(RANDOM_PER_PHASE);
    // Hold the sender back part way through until the block has emptied.
    while (char_queue.size() > RANDOM_PER_PHASE / 2) begin
      @(negedge clk);
    end
    hold_sender = 1'b1;
    while (char_valid || expected_tokens.size() > 0) begin
      @(negedge clk);
    end
    hold_sender = 1'b0;
    wait_drained();

    // Phase two: the roles of the two sides are swapped.
    sender_idle_pct    = 50;
    receiver_stall_pct = 16;
    add_random_text(RANDOM_PER_PHASE);
    wait_drained();

    // Phase three: no idling on either side. A word that starts as a keyword
    // and runs on well past every keyword length, closed by an operator
    // carrying the end mark.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    push_char(" ", 1'b1);
    push_text("continue", 1'b0);
    for (i = 8; i < LONG_WORD_CHARS; i++) begin
      push_char(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789"),
                1'b0);
    end
    push_char("+", 1'b1);
    add_random_text(RANDOM_PER_PHASE);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_tokens.size() != 0) begin
      report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/cst_pkg.sv
rtl/core/cst_front.sv
rtl/core/cst_queue.sv
rtl/core/cst_back.sv
rtl/core/char_stream_tokenizer.sv
test/char_stream_tokenizer_tb.sv
